FILE: design/mjst_pkg.sv
// ----------------------------------------------------------------------------
// Minimum-jerk servo trajectory package
// Shared widths and parameter defaults for the trajectory core.
// ----------------------------------------------------------------------------
package mjst_pkg;

  localparam int DEF_POSITION_BITS = 16;
  localparam int DEF_FRACTION_BITS = 16;
  localparam int STEP_BITS         = 16;

  typedef logic [STEP_BITS-1:0] step_t;

endpackage

FILE: design/mjst_ser_mul.sv
// ----------------------------------------------------------------------------
// Bit-serial unsigned multiplier
// Shift-and-add multiplier that retires one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module mjst_ser_mul
  import mjst_pkg::*;
#(
  parameter int A_W = DEF_FRACTION_BITS + 4,
  parameter int B_W = DEF_FRACTION_BITS + 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [A_W-1:0]   a,
  input  logic [B_W-1:0]   b,
  output logic             done,
  output logic [A_W+B_W-1:0] prod
);

  localparam int CntW = $clog2(B_W + 1);
  localparam int AccW = A_W + 1 + B_W;

  logic [A_W-1:0]  a_r;
  logic [AccW-1:0] acc_r;
  logic [CntW-1:0] cnt_r;
  logic            run_r;
  logic            done_r;
  logic [A_W:0]    hi_sum;

  assign hi_sum = acc_r[AccW-1:B_W] + (acc_r[0] ? {1'b0, a_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r   <= a;
        acc_r <= {{(A_W+1){1'b0}}, b};
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        acc_r <= {1'b0, hi_sum, acc_r[B_W-1:1]};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CntW'(B_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r[A_W+B_W-1:0];

endmodule

FILE: design/minimum_jerk_servo_trajectory_core.sv
// ----------------------------------------------------------------------------
// Minimum-jerk servo trajectory core
// A tick that starts no blend step goes from S_IDLE straight to S_EMIT; a
// blended tick first runs one bit-serial divide (S_DIV) and four passes of
// the shared bit-serial multiplier (S_SQ, S_CUBE, S_BLEND, S_OFF). One tick
// is in work at a time; the next is taken once S_EMIT places the result
// beat in the output register. Synchronous reset clears the trajectory
// state, the move length and the output register.
// ----------------------------------------------------------------------------
module minimum_jerk_servo_trajectory_core
  import mjst_pkg::*;
#(
  parameter int POSITION_BITS = DEF_POSITION_BITS,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [STEP_BITS-1:0]     cfg_wr_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [POSITION_BITS-1:0] in_target,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [POSITION_BITS-1:0] out_position,
  output logic                     out_moving
);

  localparam int P       = POSITION_BITS;
  localparam int F       = FRACTION_BITS;
  localparam int RemW    = STEP_BITS + 1;
  localparam int QW      = F + 4;
  localparam int MulAw   = (F + 4 > P) ? F + 4 : P;
  localparam int MulBw   = F + 1;
  localparam int ProdW   = MulAw + MulBw;
  localparam int PWideW  = ProdW - F;
  localparam int DivCntW = $clog2(F + 1);

  localparam logic [QW-1:0]     QBase    = QW'(10) << F;
  localparam logic [PWideW-1:0] PWideOne = PWideW'(1) << F;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SQ,
    S_CUBE,
    S_BLEND,
    S_OFF,
    S_EMIT
  } state_t;

  state_t           state_r, state_nxt;
  step_t            move_steps_r, move_steps_nxt;
  logic [P-1:0]     start_r, start_nxt;
  logic [P-1:0]     goal_r, goal_nxt;
  logic [P-1:0]     pos_r, pos_nxt;
  step_t            k_r, k_nxt;
  step_t            total_r, total_nxt;
  logic             busy_r, busy_nxt;
  logic [RemW-1:0]  rem_r, rem_nxt;
  logic [DivCntW-1:0] cnt_r, cnt_nxt;
  logic [F-1:0]     s_r, s_nxt;
  logic [F-1:0]     s2_r, s2_nxt;
  logic [F-1:0]     s3_r, s3_nxt;
  logic [F:0]       p_r, p_nxt;
  logic             mul_go_r, mul_go_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [P-1:0]     out_position_r, out_position_nxt;
  logic             out_moving_r, out_moving_nxt;

  logic             start_mv;
  logic             eff_busy;
  logic [P-1:0]     eff_goal;
  logic [P-1:0]     eff_start;
  step_t            eff_total;
  step_t            eff_k;
  step_t            k_inc;
  logic [RemW-1:0]  rem2;
  logic             div_ge;
  logic [QW-1:0]    q;
  logic             up;
  logic [P-1:0]     delta;
  logic [PWideW-1:0] p_wide;
  logic [P-1:0]     off;
  logic [MulAw-1:0] mul_a;
  logic [MulBw-1:0] mul_b;
  logic             mul_done;
  logic [ProdW-1:0] mul_prod;

  mjst_ser_mul #(
    .A_W (MulAw),
    .B_W (MulBw)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_go_r),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  assign start_mv  = !busy_r && (in_target != pos_r);
  assign eff_busy  = busy_r || start_mv;
  assign eff_goal  = start_mv ? in_target : goal_r;
  assign eff_start = start_mv ? pos_r : start_r;
  assign eff_total = start_mv ? move_steps_r : total_r;
  assign eff_k     = start_mv ? '0 : k_r;
  assign k_inc     = eff_k + 1'b1;

  assign rem2   = {rem_r[RemW-2:0], 1'b0};
  assign div_ge = rem2 >= {1'b0, total_r};

  assign q = QBase + (QW'(s2_r) << 2) + (QW'(s2_r) << 1) - (QW'(s_r) << 4) + QW'(s_r);

  assign up    = goal_r > start_r;
  assign delta = up ? (goal_r - start_r) : (start_r - goal_r);

  assign p_wide = mul_prod[ProdW-1:F];
  assign off    = mul_prod[F+P-1:F];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_SQ: begin
        mul_a = MulAw'(s_r);
        mul_b = MulBw'(s_r);
      end
      S_CUBE: begin
        mul_a = MulAw'(s2_r);
        mul_b = MulBw'(s_r);
      end
      S_BLEND: begin
        mul_a = MulAw'(q);
        mul_b = MulBw'(s3_r);
      end
      S_OFF: begin
        mul_a = MulAw'(delta);
        mul_b = p_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt        = state_r;
    move_steps_nxt   = cfg_wr_en ? cfg_wr_data : move_steps_r;
    start_nxt        = start_r;
    goal_nxt         = goal_r;
    pos_nxt          = pos_r;
    k_nxt            = k_r;
    total_nxt        = total_r;
    busy_nxt         = busy_r;
    rem_nxt          = rem_r;
    cnt_nxt          = cnt_r;
    s_nxt            = s_r;
    s2_nxt           = s2_r;
    s3_nxt           = s3_r;
    p_nxt            = p_r;
    mul_go_nxt       = 1'b0;
    out_valid_nxt    = out_valid_r && out_stall;
    out_position_nxt = out_position_r;
    out_moving_nxt   = out_moving_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          start_nxt = eff_start;
          goal_nxt  = eff_goal;
          total_nxt = eff_total;
          state_nxt = S_EMIT;
          if (eff_busy) begin
            if (eff_total == '0) begin
              pos_nxt  = eff_goal;
              busy_nxt = 1'b0;
            end else if (k_inc >= eff_total) begin
              pos_nxt  = eff_goal;
              busy_nxt = 1'b0;
              k_nxt    = '0;
            end else begin
              busy_nxt  = 1'b1;
              k_nxt     = k_inc;
              rem_nxt   = {1'b0, k_inc};
              cnt_nxt   = '0;
              state_nxt = S_DIV;
            end
          end
        end
      end
      S_DIV: begin
        rem_nxt = div_ge ? (rem2 - {1'b0, total_r}) : rem2;
        s_nxt   = {s_r[F-2:0], div_ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DivCntW'(F - 1)) begin
          state_nxt  = S_SQ;
          mul_go_nxt = 1'b1;
        end
      end
      S_SQ: begin
        if (mul_done) begin
          s2_nxt     = mul_prod[2*F-1:F];
          state_nxt  = S_CUBE;
          mul_go_nxt = 1'b1;
        end
      end
      S_CUBE: begin
        if (mul_done) begin
          s3_nxt     = mul_prod[2*F-1:F];
          state_nxt  = S_BLEND;
          mul_go_nxt = 1'b1;
        end
      end
      S_BLEND: begin
        if (mul_done) begin
          p_nxt      = (p_wide > PWideOne) ? PWideOne[F:0] : p_wide[F:0];
          state_nxt  = S_OFF;
          mul_go_nxt = 1'b1;
        end
      end
      S_OFF: begin
        if (mul_done) begin
          pos_nxt   = up ? (start_r + off) : (start_r - off);
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt    = 1'b1;
          out_position_nxt = pos_r;
          out_moving_nxt   = busy_r;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      move_steps_r   <= '0;
      start_r        <= '0;
      goal_r         <= '0;
      pos_r          <= '0;
      k_r            <= '0;
      total_r        <= '0;
      busy_r         <= 1'b0;
      cnt_r          <= '0;
      mul_go_r       <= 1'b0;
      out_valid_r    <= 1'b0;
      out_position_r <= '0;
      out_moving_r   <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      move_steps_r   <= move_steps_nxt;
      start_r        <= start_nxt;
      goal_r         <= goal_nxt;
      pos_r          <= pos_nxt;
      k_r            <= k_nxt;
      total_r        <= total_nxt;
      busy_r         <= busy_nxt;
      cnt_r          <= cnt_nxt;
      mul_go_r       <= mul_go_nxt;
      out_valid_r    <= out_valid_nxt;
      out_position_r <= out_position_nxt;
      out_moving_r   <= out_moving_nxt;
    end
    rem_r  <= rem_nxt;
    s_r    <= s_nxt;
    s2_r   <= s2_nxt;
    s3_r   <= s3_nxt;
    p_r    <= p_nxt;
  end

  assign in_stall     = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_position = out_position_r;
  assign out_moving   = out_moving_r;

`ifndef SYNTHESIS
  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && busy_r) |-> (total_r != '0 && k_r < total_r))
    else $error("step index outside the latched move length");

  a_idle_index_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (k_r == '0))
    else $error("step index not cleared while idle");

  a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == S_SQ || state_r == S_CUBE || state_r == S_BLEND
                  || state_r == S_OFF))
    else $error("multiplier finished outside a multiply state");

  a_offset_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (mul_done && state_r == S_OFF) |-> (off <= delta))
    else $error("offset exceeds the move distance");
`endif

endmodule

FILE: dv/servo_trajectory_checker.sv
// ----------------------------------------------------------------------------
// Servo trajectory checker
// Watches the configuration port and both beat channels of the trajectory
// core. It keeps its own copy of the move state, predicts position and moving
// for every accepted input beat, and compares each result beat in order.
// ----------------------------------------------------------------------------
module servo_trajectory_checker
  import mjst_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  step_t                        cfg_wr_data,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [DEF_POSITION_BITS-1:0] in_target,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [DEF_POSITION_BITS-1:0] out_position,
  input  logic                         out_moving,
  output int unsigned                  failures,
  output int unsigned                  outstanding
);

  localparam int        PB        = DEF_POSITION_BITS;
  localparam int        FB        = DEF_FRACTION_BITS;
  localparam bit [63:0] UNITY     = 64'd1 << FB;
  localparam bit [63:0] POS_MASK  = (64'd1 << PB) - 64'd1;
  localparam bit [63:0] STEP_MASK = (64'd1 << STEP_BITS) - 64'd1;

  typedef struct packed {
    logic [PB-1:0] position;
    logic          moving;
  } servo_tick_t;

  servo_tick_t expected_ticks[$];
  step_t       steps_setting;
  bit [63:0]   move_origin;
  bit [63:0]   move_goal;
  bit [63:0]   move_index;
  bit [63:0]   move_length;
  bit [63:0]   held_position;
  bit          in_motion;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    failures++;
  endtask

  function automatic bit [63:0] quintic_blend(input bit [63:0] s);
    bit [63:0] s2;
    bit [63:0] s3;
    bit [63:0] q;
    bit [63:0] p;
    s2 = (s * s) >> FB;
    s3 = (s2 * s) >> FB;
    q  = 10 * UNITY + 6 * s2 - 15 * s;
    p  = (s3 * q) >> FB;
    return (p > UNITY) ? UNITY : p;
  endfunction

  function automatic servo_tick_t step_trajectory(input bit [63:0] request);
    bit [63:0]   fraction;
    bit [63:0]   span;
    bit [63:0]   offset;
    servo_tick_t tick;
    request = request & POS_MASK;
    if (!in_motion && request != held_position) begin
      in_motion   = 1'b1;
      move_origin = held_position;
      move_goal   = request;
      move_length = steps_setting;
      move_index  = '0;
    end
    if (in_motion) begin
      if (move_length == 0) begin
        held_position = move_goal;
        in_motion     = 1'b0;
      end else begin
        move_index = (move_index + 1) & STEP_MASK;
        if (move_index >= move_length) begin
          held_position = move_goal;
          in_motion     = 1'b0;
          move_index    = '0;
        end else begin
          fraction = (move_index << FB) / move_length;
          if (move_goal > move_origin) begin
            span          = move_goal - move_origin;
            offset        = (span * quintic_blend(fraction)) >> FB;
            held_position = (move_origin + offset) & POS_MASK;
          end else begin
            span          = move_origin - move_goal;
            offset        = (span * quintic_blend(fraction)) >> FB;
            held_position = (move_origin - offset) & POS_MASK;
          end
        end
      end
    end
    tick.position = held_position[PB-1:0];
    tick.moving   = in_motion;
    return tick;
  endfunction

  always @(posedge clk) begin
    servo_tick_t seen;
    servo_tick_t want;
    if (!rst_n) begin
      expected_ticks.delete();
      steps_setting = '0;
      move_origin   = '0;
      move_goal     = '0;
      move_index    = '0;
      move_length   = '0;
      held_position = '0;
      in_motion     = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        seen.position = out_position;
        seen.moving   = out_moving;
        if (expected_ticks.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing expected, position %0d moving %0b",
                                    seen.position, seen.moving));
        end else begin
          want = expected_ticks.pop_front();
          if (seen.position !== want.position) begin
            report_mismatch($sformatf("position %0d, expected %0d",
                                      seen.position, want.position));
          end
          if (seen.moving !== want.moving) begin
            report_mismatch($sformatf("moving %0b, expected %0b at position %0d",
                                      seen.moving, want.moving, want.position));
          end
        end
      end
      if (cfg_wr_en) begin
        steps_setting = cfg_wr_data;
      end
      if (in_valid && !in_stall) begin
        expected_ticks.push_back(step_trajectory(in_target));
      end
    end
    outstanding <= expected_ticks.size();
  end

endmodule

FILE: dv/minimum_jerk_servo_trajectory_core_test.sv
// ----------------------------------------------------------------------------
// Minimum-jerk servo trajectory core testbench
// Drives directed and random position requests through the core under
// several move lengths, with random idling on both channels and one long
// hold-off on the result side, and lets the checker judge every result beat.
// ----------------------------------------------------------------------------
module minimum_jerk_servo_trajectory_core_test;
  import mjst_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned PHASES      = 8;

  logic                         clk         = 1'b0;
  logic                         rst_n       = 1'b0;
  logic                         cfg_wr_en   = 1'b0;
  step_t                        cfg_wr_data = '0;
  logic                         in_valid    = 1'b0;
  logic                         in_stall;
  logic [DEF_POSITION_BITS-1:0] in_target   = '0;
  logic                         out_valid;
  logic                         out_stall   = 1'b0;
  logic [DEF_POSITION_BITS-1:0] out_position;
  logic                         out_moving;

  int unsigned failures;
  int unsigned outstanding;
  int unsigned sender_idle_pct   = 21;
  int unsigned receiver_idle_pct = 79;
  bit          hold_request      = 1'b0;
  bit          hold_served       = 1'b0;
  int unsigned hold_left         = 0;
  int unsigned cycle_count       = 0;

  logic [DEF_POSITION_BITS-1:0] opening_targets [18] = '{
    16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000,
    16'hFFFF, 16'h0000,
    16'hFFFF, 16'd1234, 16'h0000, 16'd7, 16'd9, 16'hFFFF,
    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd1
  };
  step_t step_plan [PHASES] = '{16'd3, 16'd0, 16'd12, 16'd1, 16'd30, 16'd2, 16'd8, 16'hFFFF};

  always #5 clk = ~clk;

  minimum_jerk_servo_trajectory_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_target    (in_target),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_position (out_position),
    .out_moving   (out_moving)
  );

  servo_trajectory_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_target    (in_target),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_position (out_position),
    .out_moving   (out_moving),
    .failures     (failures),
    .outstanding  (outstanding)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // The long hold-off keeps the result side stalled while requests keep
  // coming, so the core fills up and has to stall its input.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_served) begin
      out_stall   <= 1'b1;
      hold_left   <= LONG_HOLD;
      hold_served <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end
  end

  task automatic send_request(input logic [DEF_POSITION_BITS-1:0] target);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_target <= target;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic program_move_steps(input step_t value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [DEF_POSITION_BITS-1:0] pick_target(
      input logic [DEF_POSITION_BITS-1:0] last);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 55) return last;
    if (roll < 70) return DEF_POSITION_BITS'($urandom_range(65535));
    if (roll < 77) return '0;
    if (roll < 84) return '1;
    return DEF_POSITION_BITS'(last + $urandom_range(6) - 3);
  endfunction

  initial begin
    logic [DEF_POSITION_BITS-1:0] last_target;
    int unsigned                  random_count;
    int unsigned                  phase_len;
    last_target  = '0;
    random_count = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < 18; i++) begin
      if (i == 4) program_move_steps(16'd1);
      if (i == 6) program_move_steps(16'd5);
      send_request(opening_targets[i]);
    end

    for (int p = 0; p < PHASES; p++) begin
      program_move_steps(step_plan[p]);
      phase_len = (p == PHASES - 1) ? 40 : 115;
      for (int n = 0; n < phase_len; n++) begin
        if (random_count == 283) begin
          sender_idle_pct   = 79;
          receiver_idle_pct = 21;
        end
        if (random_count == 566) begin
          sender_idle_pct   = 0;
          receiver_idle_pct = 0;
          hold_request      = 1'b1;
        end
        last_target = pick_target(last_target);
        send_request(last_target);
        random_count++;
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (120) @(negedge clk);
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
